// ===== sv/nlt_pkg.sv =====
// Package for the named lock table: request and response word types,
// request and status codes, field widths and default table geometry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nlt_pkg;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int HASH_W   = 64;
    localparam int BUCKET_W = 6;
    localparam int TIME_W   = 63;
    localparam int STATUS_W = 3;
    localparam int SLOTID_W = 5;

    // Default geometry
    localparam int BUCKETS_DEF = 64;
    localparam int SLOTS_DEF   = 32;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_LOCK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STEAL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNLOCK = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_NEW      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REUSED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REFUSED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_UNLOCKED = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOOP     = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [HASH_W-1:0]   name_hash;
        logic [BUCKET_W-1:0] bucket;
        logic [TIME_W-1:0]   now_ms;
        logic [TIME_W-1:0]   steal_after_ms;
        logic [TIME_W-1:0]   held_since;
    } req_t;

    typedef struct packed {
        logic                granted;
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   acquired_at;
        logic [SLOTID_W-1:0] slot_used;
    } rsp_t;

endpackage

`default_nettype wire

// ===== sv/named_lock_table.sv =====
// Named lock table: try-lock, steal-stale and unlock requests on a hashed
// table of lock slots. Depends on nlt_pkg.
//
// One request word is processed at a time. After acceptance the name hash
// is reduced modulo SLOTS, one hash byte per cycle, then the bucket's
// slots are probed through the single registered table read port, one slot
// per cycle, stopping at the first deciding slot. An unlock with held_since
// of zero and the unused request code skip the reduction and the probe. A
// response still stalled at the output holds the next result back. After
// reset the table is swept to free, one entry per cycle, over all
// BUCKETS*SLOTS entries (2048 by default) before the first request is
// accepted. A finished response waits in an output register, so the next
// request may be accepted while it is stalled.
`timescale 1ns / 1ps
`default_nettype none

module named_lock_table #(
    parameter int BUCKETS = nlt_pkg::BUCKETS_DEF,
    parameter int SLOTS   = nlt_pkg::SLOTS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_stall,
    input  wire nlt_pkg::req_t req,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output nlt_pkg::rsp_t     rsp
);

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ROW_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int DEPTH   = BUCKETS * SLOTS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int HASH_W  = nlt_pkg::HASH_W;
    localparam int TIME_W  = nlt_pkg::TIME_W;
    localparam int ENTRY_W = HASH_W + TIME_W;
    localparam int BKT_N   = 2 ** nlt_pkg::BUCKET_W;
    localparam int REM_N   = 2 ** SLOT_W;

    localparam logic [SLOT_W:0]     SLOTS_C     = (SLOT_W + 1)'(SLOTS);
    localparam logic [SLOT_W-1:0]   SLOT_LAST   = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]    CNT_SLOTS   = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0]    CNT_LAST    = CNT_W'(SLOTS - 1);
    localparam logic [ADDR_W-1:0]   SLOTS_A     = ADDR_W'(SLOTS);
    localparam logic [ADDR_W-1:0]   ADDR_LAST   = ADDR_W'(DEPTH - 1);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MOD    = 3'd2;
    localparam logic [2:0] ST_PROBE  = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    // Constant residue tables
    typedef logic [255:0][SLOT_W-1:0]     byte_res_t;
    typedef logic [REM_N-1:0][SLOT_W-1:0] carry_res_t;
    typedef logic [BKT_N-1:0][ROW_W-1:0]  row_tab_t;

    // Residue of each byte value modulo SLOTS
    function automatic byte_res_t make_byte_res();
        byte_res_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = SLOT_W'(i % SLOTS);
        end
        return t;
    endfunction

    // Residue of a running remainder shifted up by one byte
    function automatic carry_res_t make_carry_res();
        carry_res_t t;
        for (int i = 0; i < REM_N; i++) begin
            t[i] = SLOT_W'((i * 256) % SLOTS);
        end
        return t;
    endfunction

    // Row of each bucket number modulo BUCKETS
    function automatic row_tab_t make_row_of();
        row_tab_t t;
        for (int i = 0; i < BKT_N; i++) begin
            t[i] = ROW_W'(i % BUCKETS);
        end
        return t;
    endfunction

    localparam byte_res_t  BYTE_RES  = make_byte_res();
    localparam carry_res_t CARRY_RES = make_carry_res();
    localparam row_tab_t   ROW_OF    = make_row_of();

    // Fold one hash byte into the running remainder modulo SLOTS
    function automatic logic [SLOT_W-1:0] hash_mod_step(
        input logic [SLOT_W-1:0] r_in,
        input logic [7:0]        oct_in
    );
        logic [SLOT_W:0] sum;
        sum = {1'b0, CARRY_RES[r_in]} + {1'b0, BYTE_RES[oct_in]};
        if (sum >= SLOTS_C) begin
            sum = sum - SLOTS_C;
        end
        return sum[SLOT_W-1:0];
    endfunction

    // Control state
    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [2:0]        mod_cnt_reg, mod_cnt_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic              cmp_last_reg, cmp_last_next;
    logic              have_free_reg, have_free_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Payload state
    nlt_pkg::req_t     req_reg, req_next;
    logic [TIME_W-1:0] now_eff_reg, now_eff_next;
    logic [SLOT_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [SLOT_W-1:0] issue_slot_reg, issue_slot_next;
    logic [SLOT_W-1:0] cmp_slot_reg, cmp_slot_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    nlt_pkg::rsp_t     pend_reg, pend_next;
    nlt_pkg::rsp_t     rsp_reg, rsp_next;

    // Table memory
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // Probe compare unit
    logic [HASH_W-1:0] st_hash;
    logic [TIME_W-1:0] st_time;
    logic              hash_eq;
    logic              time_zero;
    logic [TIME_W:0]   age;
    logic              stale;
    logic [7:0]        hash_oct;
    logic              is_unlock;
    logic              steal;

    assign st_hash   = rd_data_reg[ENTRY_W-1 -: HASH_W];
    assign st_time   = rd_data_reg[TIME_W-1:0];
    assign hash_eq   = (st_hash == req_reg.name_hash);
    assign time_zero = (st_time == '0);
    assign age       = {1'b0, now_eff_reg} - {1'b0, st_time};
    assign stale     = !age[TIME_W] && (age[TIME_W-1:0] >= req_reg.steal_after_ms);
    assign hash_oct  = req_reg.name_hash[{~mod_cnt_reg, 3'b000} +: 8];
    assign is_unlock = (req_reg.func == nlt_pkg::FUNC_UNLOCK);
    assign steal     = (req_reg.func == nlt_pkg::FUNC_STEAL);
    assign rd_addr   = row_base_reg + ADDR_W'(issue_slot_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        mod_cnt_next    = mod_cnt_reg;
        issue_cnt_next  = issue_cnt_reg;
        cmp_valid_next  = 1'b0;
        cmp_last_next   = cmp_last_reg;
        have_free_next  = have_free_reg;
        rsp_valid_next  = rsp_valid_reg;
        req_next        = req_reg;
        now_eff_next    = now_eff_reg;
        base_next       = base_reg;
        row_base_next   = row_base_reg;
        issue_slot_next = issue_slot_reg;
        cmp_slot_next   = cmp_slot_reg;
        free_slot_next  = free_slot_reg;
        pend_next       = pend_reg;
        rsp_next        = rsp_reg;
        wr_en           = 1'b0;
        wr_addr         = clr_addr_reg;
        wr_data         = '0;

        // Drop the response word once taken
        if (rsp_valid_reg && !rsp_stall) begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the table to free, one entry per cycle
                wr_en         = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_LAST) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_valid) begin
                    req_next     = req;
                    now_eff_next = (req.now_ms == '0) ? TIME_W'(1) : req.now_ms;
                    base_next    = '0;
                    mod_cnt_next = '0;
                    if (req.func == nlt_pkg::FUNC_NONE
                        || (req.func == nlt_pkg::FUNC_UNLOCK && req.held_since == '0)) begin
                        pend_next  = '{granted: 1'b0, status: nlt_pkg::STAT_NOOP,
                                       acquired_at: '0, slot_used: '0};
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_MOD;
                    end
                end
            end

            ST_MOD:
            begin
                // Reduce the hash one byte per cycle, form the row base
                base_next     = hash_mod_step(base_reg, hash_oct);
                row_base_next = ADDR_W'(ROW_OF[req_reg.bucket]) * SLOTS_A;
                mod_cnt_next  = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == 3'd7) begin
                    issue_slot_next = base_next;
                    issue_cnt_next  = '0;
                    have_free_next  = 1'b0;
                    state_next      = ST_PROBE;
                end
            end

            ST_PROBE:
            begin
                // Issue the next slot read
                if (issue_cnt_reg < CNT_SLOTS) begin
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                    issue_slot_next = (issue_slot_reg == SLOT_LAST) ? '0
                                                                   : issue_slot_reg + 1'b1;
                    cmp_valid_next  = 1'b1;
                    cmp_slot_next   = issue_slot_reg;
                    cmp_last_next   = (issue_cnt_reg == CNT_LAST);
                end

                // Compare the slot read last cycle
                wr_addr = row_base_reg + ADDR_W'(cmp_slot_reg);
                if (cmp_valid_reg) begin
                    if (is_unlock) begin
                        if (hash_eq && st_time == req_reg.held_since) begin
                            wr_en      = 1'b1;
                            wr_data    = {req_reg.name_hash, {TIME_W{1'b0}}};
                            pend_next  = '{granted: 1'b0, status: nlt_pkg::STAT_UNLOCKED,
                                           acquired_at: '0,
                                           slot_used: nlt_pkg::SLOTID_W'(cmp_slot_reg)};
                            state_next = ST_RESULT;
                        end else if (cmp_last_reg) begin
                            pend_next  = '{granted: 1'b0, status: nlt_pkg::STAT_NOOP,
                                           acquired_at: '0, slot_used: '0};
                            state_next = ST_RESULT;
                        end
                    end else if (hash_eq) begin
                        if (time_zero || (steal && stale)) begin
                            wr_en     = 1'b1;
                            wr_data   = {req_reg.name_hash, now_eff_reg};
                            pend_next = '{granted: 1'b1, status: nlt_pkg::STAT_REUSED,
                                          acquired_at: now_eff_reg,
                                          slot_used: nlt_pkg::SLOTID_W'(cmp_slot_reg)};
                        end else begin
                            pend_next = '{granted: 1'b0, status: nlt_pkg::STAT_REFUSED,
                                          acquired_at: '0, slot_used: '0};
                        end
                        state_next = ST_RESULT;
                    end else begin
                        // Remember the first free slot
                        if (time_zero && !have_free_reg) begin
                            have_free_next = 1'b1;
                            free_slot_next = cmp_slot_reg;
                        end
                        if (cmp_last_reg) begin
                            if (have_free_reg || time_zero) begin
                                wr_en     = 1'b1;
                                wr_addr   = row_base_reg + ADDR_W'(have_free_reg ? free_slot_reg
                                                                                 : cmp_slot_reg);
                                wr_data   = {req_reg.name_hash, now_eff_reg};
                                pend_next = '{granted: 1'b1, status: nlt_pkg::STAT_NEW,
                                              acquired_at: now_eff_reg,
                                              slot_used: nlt_pkg::SLOTID_W'(
                                                  have_free_reg ? free_slot_reg
                                                                : cmp_slot_reg)};
                            end else begin
                                pend_next = '{granted: 1'b0, status: nlt_pkg::STAT_FULL,
                                              acquired_at: '0, slot_used: '0};
                            end
                            state_next = ST_RESULT;
                        end
                    end
                end
            end

            ST_RESULT:
            begin
                // Hand the word to the output register once it is free
                if (!rsp_valid_reg || !rsp_stall) begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            mod_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            have_free_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            mod_cnt_reg   <= mod_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            have_free_reg <= have_free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        now_eff_reg    <= now_eff_next;
        base_reg       <= base_next;
        row_base_reg   <= row_base_next;
        issue_slot_reg <= issue_slot_next;
        cmp_slot_reg   <= cmp_slot_next;
        free_slot_reg  <= free_slot_next;
        pend_reg       <= pend_next;
        rsp_reg        <= rsp_next;
    end

    // Table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/nlt_check.sv =====
// Port checker for the named lock table, bound to its top level.
// Depends on nlt_pkg and named_lock_table.
`timescale 1ns / 1ps
`default_nettype none

module nlt_check (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire nlt_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire nlt_pkg::rsp_t rsp
);

    // Hold a stalled response word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // Stall the request side after each accepted word
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while another is in work");

    // Grant only with a grant status and a nonzero time
    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.granted == (rsp.status == nlt_pkg::STAT_NEW
                                       || rsp.status == nlt_pkg::STAT_REUSED))
                      && (rsp.granted == (rsp.acquired_at != '0)))
        else $error("grant flag, status and time disagree");

    // Report no slot when nothing was written or released
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == nlt_pkg::STAT_REFUSED
                      || rsp.status == nlt_pkg::STAT_FULL
                      || rsp.status == nlt_pkg::STAT_NOOP) |-> rsp.slot_used == '0)
        else $error("slot reported without a table write");

endmodule

bind named_lock_table nlt_check u_nlt_check (.*);

`default_nettype wire

// ===== test/named_lock_table_tb.sv =====
// Self-checking testbench for named_lock_table: a directed table of lock,
// steal and unlock words, then randomized lock traffic checked against an
// in-bench prediction of the slot store. Depends on nlt_pkg and named_lock_table.
`timescale 1ns / 1ps

module named_lock_table_tb;

    localparam int BUCKETS     = nlt_pkg::BUCKETS_DEF;
    localparam int SLOTS       = nlt_pkg::SLOTS_DEF;
    localparam int FUNC_W      = nlt_pkg::FUNC_W;
    localparam int HASH_W      = nlt_pkg::HASH_W;
    localparam int BUCKET_W    = nlt_pkg::BUCKET_W;
    localparam int TIME_W      = nlt_pkg::TIME_W;
    localparam int SLOTID_W    = nlt_pkg::SLOTID_W;
    localparam int RAND_ITEMS  = 520;
    localparam int CALM_ITEMS  = 60;
    localparam int PAUSE_AT    = 300;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 64;
    localparam int WATCHDOG    = 20000;

    localparam logic [TIME_W-1:0] T_MAX  = '1;
    localparam logic [HASH_W-1:0] H_ONES = '1;
    localparam nlt_pkg::rsp_t     CALC   = '0;

    typedef struct {
        nlt_pkg::req_t word;
        bit            typed;
        nlt_pkg::rsp_t want;
    } plan_row_t;

    typedef struct {
        logic [HASH_W-1:0]   name;
        logic [BUCKET_W-1:0] bucket;
        logic [TIME_W-1:0]   since;
    } lease_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    nlt_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    nlt_pkg::rsp_t rsp;

    // predicted slot store, cleared like the block after reset
    bit [HASH_W-1:0] lock_hash [BUCKETS*SLOTS];
    bit [TIME_W-1:0] lock_time [BUCKETS*SLOTS];

    nlt_pkg::rsp_t     rsp_due [$];
    lease_t            lease_log [$];
    logic [HASH_W-1:0] name_pool [16];
    logic [TIME_W-1:0] wall_ms;

    bit            last_stretch = 1'b0;
    bit            held_off     = 1'b0;
    int            mismatches   = 0;
    int            results_seen = 0;
    int            stall_left   = 0;
    int            open_left    = 0;
    int            dead_cycles  = 0;
    nlt_pkg::rsp_t owed;

    named_lock_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] rand63();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // Advance the wall clock; now and then hand out zero or a random full-width time.
    function automatic logic [TIME_W-1:0] next_now();
        int roll;
        roll = $urandom_range(0, 29);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return rand63();
        wall_ms = wall_ms + TIME_W'($urandom_range(0, 40));
        return wall_ms;
    endfunction

    function automatic nlt_pkg::req_t mk_word(input logic [FUNC_W-1:0] func,
                                              input logic [HASH_W-1:0] name,
                                              input logic [BUCKET_W-1:0] bucket,
                                              input logic [TIME_W-1:0] now,
                                              input logic [TIME_W-1:0] tmo,
                                              input logic [TIME_W-1:0] held);
        nlt_pkg::req_t w;
        w.func           = func;
        w.name_hash      = name;
        w.bucket         = bucket;
        w.now_ms         = now;
        w.steal_after_ms = tmo;
        w.held_since     = held;
        return w;
    endfunction

    // Apply one request word to the predicted store and return its response.
    function automatic nlt_pkg::rsp_t settle_request(input nlt_pkg::req_t w);
        nlt_pkg::rsp_t     r;
        int                row;
        int                base;
        int                s;
        int                k;
        int                free_s;
        bit                have_free;
        bit                stale;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] t;
        r         = '0;
        row       = (int'(w.bucket) % BUCKETS) * SLOTS;
        base      = int'(w.name_hash % 64'(SLOTS));
        have_free = 1'b0;
        free_s    = 0;

        // release the first slot holding this name at the caller's time
        if (w.func == nlt_pkg::FUNC_UNLOCK) begin
            r.status = nlt_pkg::STAT_NOOP;
            if (w.held_since != '0) begin
                for (k = 0; k < SLOTS; k++) begin
                    s = (base + k) % SLOTS;
                    if (lock_hash[row+s] == w.name_hash && lock_time[row+s] == w.held_since)
                    begin
                        lock_time[row+s] = '0;
                        r.status         = nlt_pkg::STAT_UNLOCKED;
                        r.slot_used      = SLOTID_W'(s);
                        return r;
                    end
                end
            end
            return r;
        end
        if (w.func == nlt_pkg::FUNC_NONE) begin
            r.status = nlt_pkg::STAT_NOOP;
            return r;
        end

        // lock: the first slot with this name decides, else the first free one
        now = (w.now_ms == '0) ? TIME_W'(1) : w.now_ms;
        for (k = 0; k < SLOTS; k++) begin
            s = (base + k) % SLOTS;
            t = lock_time[row+s];
            if (lock_hash[row+s] == w.name_hash) begin
                stale = (w.func == nlt_pkg::FUNC_STEAL) && now >= t
                        && (now - t) >= w.steal_after_ms;
                if (t == '0 || stale) begin
                    lock_time[row+s] = now;
                    r.granted        = 1'b1;
                    r.status         = nlt_pkg::STAT_REUSED;
                    r.acquired_at    = now;
                    r.slot_used      = SLOTID_W'(s);
                end else begin
                    r.status = nlt_pkg::STAT_REFUSED;
                end
                return r;
            end
            if (t == '0 && !have_free) begin
                have_free = 1'b1;
                free_s    = s;
            end
        end
        if (have_free) begin
            lock_hash[row+free_s] = w.name_hash;
            lock_time[row+free_s] = now;
            r.granted             = 1'b1;
            r.status              = nlt_pkg::STAT_NEW;
            r.acquired_at         = now;
            r.slot_used           = SLOTID_W'(free_s);
        end else begin
            r.status = nlt_pkg::STAT_FULL;
        end
        return r;
    endfunction

    // Offer one request word, maybe after a gap, and hold it until taken.
    task automatic send_word(input nlt_pkg::req_t w, input bit typed,
                             input nlt_pkg::rsp_t typed_rsp);
        nlt_pkg::rsp_t guess;
        lease_t        l;
        guess = settle_request(w);
        if (guess.granted) begin
            l.name   = w.name_hash;
            l.bucket = w.bucket;
            l.since  = guess.acquired_at;
            lease_log.push_back(l);
        end
        if (!last_stretch && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        rsp_due.push_back(typed ? typed_rsp : guess);
    endtask

    // Lock fresh names into one bucket until it runs out of slots.
    task automatic fill_bucket(input logic [BUCKET_W-1:0] bucket);
        int j;
        for (j = 0; j <= SLOTS; j++)
            send_word(mk_word(nlt_pkg::FUNC_LOCK, {$urandom, $urandom}, bucket, next_now(),
                              rand63(), rand63()), 1'b0, CALC);
    endtask

    function automatic void report_field(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Response side: check each accepted word, then schedule the next stall.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_due.size() == 0) begin
                $display("%0t ns: response word %h with nothing outstanding", $time, rsp);
                mismatches++;
            end else begin
                owed = rsp_due.pop_front();
                report_field("granted", 64'(owed.granted), 64'(rsp.granted));
                report_field("status", 64'(owed.status), 64'(rsp.status));
                report_field("acquired_at", 64'(owed.acquired_at), 64'(rsp.acquired_at));
                report_field("slot_used", 64'(owed.slot_used), 64'(rsp.slot_used));
            end
        end
        if (results_seen == HOLD_AT && !held_off) begin
            held_off   = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
        end else if (last_stretch) begin
            rsp_stall <= 1'b0;
        end else if (open_left > 0) begin
            open_left--;
            rsp_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
        end else begin
            open_left = $urandom_range(1, 40);
            rsp_stall <= 1'b0;
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            dead_cycles = 0;
        else
            dead_cycles++;
        if (dead_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        plan_row_t           lock_plan [$];
        lease_t              l;
        nlt_pkg::req_t       w;
        int                  n;
        int                  pick;
        int                  idx;
        logic [BUCKET_W-1:0] b;
        logic [TIME_W-1:0]   tmo;

        // names: a few random, hash zero, the rest colliding on one start slot
        foreach (name_pool[i])
            name_pool[i] = (i % 4 == 0) ? {$urandom, $urandom} :
                           (i == 1) ? '0 : 64'(SLOTS * i + 5);
        wall_ms = TIME_W'($urandom_range(1000, 100000));

        // hash zero against the cleared store; time zero counts as one
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, '0, 6'd0, '0, '0, '0),
                            1'b1, nlt_pkg::rsp_t'{1'b1, nlt_pkg::STAT_REUSED, TIME_W'(1),
                                                  SLOTID_W'(0)}});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, '0, 6'd0, 63'd5, '0, '0),
                            1'b1, nlt_pkg::rsp_t'{1'b0, nlt_pkg::STAT_REFUSED, '0, '0}});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_STEAL, '0, 6'd0, 63'd1, '0, '0),
                            1'b0, CALC});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_UNLOCK, '0, 6'd0, 63'd9, '0,
                                                63'd1),
                            1'b1, nlt_pkg::rsp_t'{1'b0, nlt_pkg::STAT_UNLOCKED, '0,
                                                  SLOTID_W'(0)}});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_UNLOCK, '0, 6'd0, 63'd9, '0, '0),
                            1'b1, nlt_pkg::rsp_t'{1'b0, nlt_pkg::STAT_NOOP, '0, '0}});
        // unused code and extremes of every field
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_NONE, H_ONES, 6'd63, T_MAX, T_MAX,
                                                T_MAX),
                            1'b1, nlt_pkg::rsp_t'{1'b0, nlt_pkg::STAT_NOOP, '0, '0}});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, H_ONES, 6'd63, T_MAX, T_MAX,
                                                T_MAX),
                            1'b1, nlt_pkg::rsp_t'{1'b1, nlt_pkg::STAT_NEW, T_MAX,
                                                  SLOTID_W'(SLOTS - 1)}});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, H_ONES, 6'd63, 63'd7, '0,
                                                '0),
                            1'b1, nlt_pkg::rsp_t'{1'b0, nlt_pkg::STAT_REFUSED, '0, '0}});
        // steal: age below timeout, and a stored time later than now
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_STEAL, H_ONES, 6'd63, T_MAX, T_MAX,
                                                '0),
                            1'b0, CALC});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_STEAL, H_ONES, 6'd63, '0, '0, '0),
                            1'b0, CALC});
        // unlock with the wrong time, then the right one; freed slot keeps its name
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_UNLOCK, H_ONES, 6'd63, '0, '0,
                                                T_MAX - 1),
                            1'b1, nlt_pkg::rsp_t'{1'b0, nlt_pkg::STAT_NOOP, '0, '0}});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_UNLOCK, H_ONES, 6'd63, '0, '0,
                                                T_MAX),
                            1'b1, nlt_pkg::rsp_t'{1'b0, nlt_pkg::STAT_UNLOCKED, '0,
                                                  SLOTID_W'(SLOTS - 1)}});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, H_ONES, 6'd63, 63'd1000,
                                                '0, '0),
                            1'b0, CALC});
        // names sharing a start slot probe onward
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, 64'd35, 6'd1, 63'd200, '0,
                                                '0),
                            1'b0, CALC});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, 64'd3, 6'd1, 63'd201, '0,
                                                '0),
                            1'b0, CALC});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, 64'd3, 6'd1, 63'd202, '0,
                                                '0),
                            1'b0, CALC});
        // probe wraps past the last slot
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, 64'd63, 6'd3, 63'd300, '0,
                                                '0),
                            1'b0, CALC});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, 64'd31, 6'd3, 63'd301, '0,
                                                '0),
                            1'b0, CALC});
        // steal just before and just at the timeout
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_LOCK, 64'd77, 6'd2, 63'd100, '0,
                                                '0),
                            1'b0, CALC});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_STEAL, 64'd77, 6'd2, 63'd149,
                                                63'd50, '0),
                            1'b0, CALC});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_STEAL, 64'd77, 6'd2, 63'd150,
                                                63'd50, '0),
                            1'b0, CALC});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_UNLOCK, 64'd77, 6'd2, '0, '0,
                                                63'd100),
                            1'b0, CALC});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_UNLOCK, 64'd77, 6'd2, '0, '0,
                                                63'd150),
                            1'b0, CALC});
        lock_plan.push_back(plan_row_t'{mk_word(nlt_pkg::FUNC_STEAL, '0, 6'd0, 63'd20, 63'd5,
                                                '0),
                            1'b0, CALC});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (lock_plan[i])
            send_word(lock_plan[i].word, lock_plan[i].typed, lock_plan[i].want);
        fill_bucket(6'd9);

        for (n = 0; n < RAND_ITEMS; n++) begin
            last_stretch = (n >= RAND_ITEMS - CALM_ITEMS);

            // drain everything once with the request side quiet
            if (n == PAUSE_AT) begin
                req_valid <= 1'b0;
                while (rsp_due.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            if (n % 200 == 150)
                fill_bucket(BUCKET_W'($urandom_range(0, 3)));

            pick = $urandom_range(0, 99);
            b    = ($urandom_range(0, 4) == 0) ? BUCKET_W'($urandom_range(0, 63)) :
                                                 BUCKET_W'($urandom_range(0, 3));
            tmo  = ($urandom_range(0, 9) == 0) ? rand63() : TIME_W'($urandom_range(0, 60));
            if (pick < 60) begin
                w = mk_word(pick < 35 ? nlt_pkg::FUNC_LOCK : nlt_pkg::FUNC_STEAL,
                            name_pool[$urandom_range(0, 15)], b, next_now(), tmo, rand63());
            end else if (pick < 85 && lease_log.size() > 0) begin
                // release a lock taken earlier, with its own acquisition time
                idx = $urandom_range(0, lease_log.size() - 1);
                l   = lease_log[idx];
                lease_log.delete(idx);
                w = mk_word(nlt_pkg::FUNC_UNLOCK, l.name, l.bucket, rand63(), rand63(),
                            l.since);
            end else if (pick < 90) begin
                w = mk_word(nlt_pkg::FUNC_UNLOCK, name_pool[$urandom_range(0, 15)], b,
                            rand63(), tmo, $urandom_range(0, 1) ? '0 : wall_ms);
            end else if (pick < 95) begin
                w = mk_word(nlt_pkg::FUNC_NONE, {$urandom, $urandom},
                            BUCKET_W'($urandom_range(0, 63)), rand63(), rand63(), rand63());
            end else begin
                w = mk_word(FUNC_W'($urandom_range(0, 3)), {$urandom, $urandom},
                            BUCKET_W'($urandom_range(0, 63)), rand63(), rand63(), rand63());
            end
            send_word(w, 1'b0, CALC);
        end

        // drop valid and let the last responses come home
        req_valid <= 1'b0;
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
